// ===== src/mkf_pkg.sv =====
package mkf_pkg;

    localparam int unsigned ResMax = 21;
    localparam int unsigned NumLanes = 3;

    typedef logic [4:0]  t_res;
    typedef logic [20:0] t_mag;

    typedef struct packed {
        logic err;
        t_mag mag;
    } t_lane_out;

endpackage

// ===== src/mkf_lane.sv =====
module mkf_lane (
    input  logic                 i_clk,
    input  logic [31:0]          i_bits,
    input  mkf_pkg::t_res        i_res,
    output mkf_pkg::t_lane_out   o_lane
);

    logic        sign;
    logic [7:0]  expo;
    logic [23:0] sig;
    logic [9:0]  sh;
    logic [5:0]  rsh;
    logic [23:0] shifted;
    logic        rej;
    mkf_pkg::t_lane_out n_lane;
    mkf_pkg::t_lane_out r_lane;

    // mag = sig * 2^(expo-150+res); expo<127 and res<=21 keep it below 2^21
    always_comb begin
        sign    = i_bits[31];
        expo    = i_bits[30:23];
        sig     = {1'b1, i_bits[22:0]};
        sh      = 10'd150 - {2'b00, expo} - {5'd0, i_res};
        rsh     = (sh > 10'd63) ? 6'd63 : sh[5:0];
        shifted = (sh > 10'd23) ? 24'd0 : (sig >> rsh);
        rej     = (expo >= 8'd127);
        n_lane.mag = (rej || expo == 8'd0) ? '0 : shifted[20:0];
        n_lane.err = rej || (sign && n_lane.mag != '0);
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_lane = r_lane;

endmodule

// ===== src/mkf_merge.sv =====
module mkf_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  mkf_pkg::t_res       i_res,
    input  mkf_pkg::t_lane_out  i_x,
    input  mkf_pkg::t_lane_out  i_y,
    input  mkf_pkg::t_lane_out  i_z,
    output logic                o_vld,
    output logic [63:0]         o_key,
    output logic                o_err
);

    logic [63:0] n_key;
    logic        n_err;
    logic [63:0] r_key;
    logic        r_err;
    logic        r_vld;

    always_comb begin
        n_err = i_x.err | i_y.err | i_z.err;
        n_key = '0;
        for (int i = 0; i < mkf_pkg::ResMax; i++) begin
            if (5'(i) < i_res) begin
                n_key[3*i]   = i_x.mag[i];
                n_key[3*i+1] = i_y.mag[i];
                n_key[3*i+2] = i_z.mag[i];
            end
        end
        n_key[6'(7'd3 * {2'b00, i_res})] = 1'b1;
        if (n_err) begin
            n_key = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_key <= n_key;
        r_err <= n_err;
    end

    assign o_vld = r_vld;
    assign o_key = r_key;
    assign o_err = r_err;

endmodule

// ===== src/morton_key_3d_from_float_unit.sv =====
// 3-D Morton leaf key from three single-precision coordinates.
// Input: pulse start with i_x_bits, i_y_bits, i_z_bits; accepted when busy
// is low. busy is always low, so one word enters every cycle.
// Output: o_valid strobes for one cycle with o_leaf_key and o_range_error,
// after the lane registers and then the merge register. Throughput is one word per cycle, set
// by three parallel float scaling lanes and one registered merge stage.
// The receiver cannot stall; every result shows for exactly one cycle.
// Config: cfg_valid/cfg_ready write cfg_data[4:0] as resolution; values
// above 21 act as 21. cfg_ready is always high; write only while idle.
// Reset: synchronous, active-low i_rst_n; resolution returns to 10 and
// pending strobes are dropped.
// Errors (NaN, infinity, value >= 1.0, truncated value negative) give key 0
// with o_range_error set.
module morton_key_3d_from_float_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_x_bits,
    input  logic [31:0] i_y_bits,
    input  logic [31:0] i_z_bits,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    output logic        o_valid,
    output logic [63:0] o_leaf_key,
    output logic        o_range_error
);

    mkf_pkg::t_res      r_res;
    mkf_pkg::t_res      res_eff;
    mkf_pkg::t_res      r_res_d;
    logic               r_vld;
    mkf_pkg::t_lane_out lane_x;
    mkf_pkg::t_lane_out lane_y;
    mkf_pkg::t_lane_out lane_z;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign res_eff   = (r_res > 5'(mkf_pkg::ResMax)) ? 5'(mkf_pkg::ResMax) : r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= 5'd10;
            r_vld <= 1'b0;
        end else begin
            if (cfg_valid) begin
                r_res <= cfg_data;
            end
            r_vld <= start;
        end
        r_res_d <= res_eff;
    end

    mkf_lane u_lane_x (.i_clk(i_clk), .i_bits(i_x_bits), .i_res(res_eff), .o_lane(lane_x));
    mkf_lane u_lane_y (.i_clk(i_clk), .i_bits(i_y_bits), .i_res(res_eff), .o_lane(lane_y));
    mkf_lane u_lane_z (.i_clk(i_clk), .i_bits(i_z_bits), .i_res(res_eff), .o_lane(lane_z));

    mkf_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld),
        .i_res   (r_res_d),
        .i_x     (lane_x),
        .i_y     (lane_y),
        .i_z     (lane_z),
        .o_vld   (o_valid),
        .o_key   (o_leaf_key),
        .o_err   (o_range_error)
    );

endmodule
